// File: hdl/qsfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsfa_pkg
// Shared types and constants of the quad segment frame assembler.
// ----------------------------------------------------------------------------
package qsfa_pkg;

  localparam int unsigned FNUM_W   = 32;
  localparam int unsigned QUAD_W   = 2;
  localparam int unsigned NQUAD    = 4;
  localparam int unsigned QCNT_W   = 3;
  localparam int unsigned DMG_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_QUAD_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_MODE   = 1'b1;

  localparam logic [QCNT_W-1:0] QUAD_COUNT_RST = 3'd4;
  localparam logic [FNUM_W-1:0] FRAME_JUMP_MAX = 32'd10;
  localparam logic [DMG_W-1:0]  LINK_ERR_DMG   = 8'hE0;
  localparam logic [DMG_W-1:0]  DUP_QUAD_DMG   = 8'hD0;

  typedef struct packed {
    logic              end_frame_error;
    logic              rx_overflow;
    logic              len_fault;
    logic              short_read;
    logic              read_fail;
    logic [FNUM_W-1:0] frame_number;
    logic [QUAD_W-1:0] quad_id;
  } seg_t;

  typedef struct packed {
    logic              accepted;
    logic              frame_start;
    logic [QCNT_W-1:0] segment_index;
    logic [DMG_W-1:0]  damage_bits;
    logic              user_damage;
    logic [QCNT_W-1:0] missing_quads;
    logic [FNUM_W-1:0] frame_count;
  } res_t;

  typedef struct packed {
    logic [QCNT_W-1:0] segs;
    logic [NQUAD-1:0]  seen;
    logic [FNUM_W-1:0] last_frame;
  } frm_state_t;

  typedef struct packed {
    logic [QCNT_W-1:0] quad_count;
    logic              sequence_mode;
  } cfg_t;

endpackage

// File: hdl/quad_segment_frame_assembler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_segment_frame_assembler_top
// Assembles detector frames out of up to four quadrant segments.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one received segment per item, valid/stall.
//   Result channel (out_*): exactly one result item per segment, valid/stall.
//   Config channel (cfg_*): index 0 quad_count, index 1 sequence_mode;
//   cfg_ready is always high, write only while the block is idle.
// Datapath: an accepted item is held in the input register, and its result
//   is loaded from there into the output register.
// Throughput: one item per cycle while the output does not stall; the frame
//   state is updated by a single combinational pass between input and output
//   register, so consecutive items see each other's update without bubbles.
// Reset: rst_n (sync, active low) clears both stages, the frame state,
//   and sets quad_count to 4 and sequence_mode to 0.
// Stall: while out_stall holds a pending result, the input register keeps
//   its item and in_stall rises only if that register is also full.
// ----------------------------------------------------------------------------
module quad_segment_frame_assembler_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [qsfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qsfa_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_end_frame_error,
  input  logic                               in_rx_overflow,
  input  logic                               in_len_fault,
  input  logic                               in_short_read,
  input  logic                               in_read_fail,
  input  logic [qsfa_pkg::FNUM_W-1:0]        in_frame_number,
  input  logic [qsfa_pkg::QUAD_W-1:0]        in_quad_id,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_accepted,
  output logic                               out_frame_start,
  output logic [qsfa_pkg::QCNT_W-1:0]        out_segment_index,
  output logic [qsfa_pkg::DMG_W-1:0]         out_damage_bits,
  output logic                               out_user_damage,
  output logic [qsfa_pkg::QCNT_W-1:0]        out_missing_quads,
  output logic [qsfa_pkg::FNUM_W-1:0]        out_frame_count
);
  import qsfa_pkg::*;

  cfg_t       cfg;
  seg_t       seg_r;
  logic       seg_valid_r;
  frm_state_t state_r, state_nxt;
  res_t       res_nxt, res_r;
  logic       out_valid_r;
  logic       out_free, out_load;

  qsfa_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  qsfa_seg_update u_upd (
    .cfg (cfg),
    .cur (state_r),
    .seg (seg_r),
    .nxt (state_nxt),
    .res (res_nxt)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = seg_valid_r && out_free;
  assign in_stall = seg_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_valid_r <= 1'b0;
    end else if (!in_stall) begin
      seg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      seg_r.end_frame_error <= in_end_frame_error;
      seg_r.rx_overflow     <= in_rx_overflow;
      seg_r.len_fault       <= in_len_fault;
      seg_r.short_read      <= in_short_read;
      seg_r.read_fail       <= in_read_fail;
      seg_r.frame_number    <= in_frame_number;
      seg_r.quad_id         <= in_quad_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (out_load) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= seg_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = res_r.accepted;
  assign out_frame_start   = res_r.frame_start;
  assign out_segment_index = res_r.segment_index;
  assign out_damage_bits   = res_r.damage_bits;
  assign out_user_damage   = res_r.user_damage;
  assign out_missing_quads = res_r.missing_quads;
  assign out_frame_count   = res_r.frame_count;

endmodule

// File: hdl/qsfa_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsfa_cfg_regs
// Configuration registers: quad count and sequence mode.
// ----------------------------------------------------------------------------
module qsfa_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [qsfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qsfa_pkg::CFG_DAT_W-1:0]     cfg_data,
  output qsfa_pkg::cfg_t                     cfg
);
  import qsfa_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quad_count    <= QUAD_COUNT_RST;
      cfg_r.sequence_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_QUAD_COUNT: cfg_r.quad_count    <= cfg_data;
        REG_SEQ_MODE:   cfg_r.sequence_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/qsfa_seg_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsfa_seg_update
// Per-segment frame bookkeeping: next frame state and the result item.
// ----------------------------------------------------------------------------
module qsfa_seg_update (
  input  qsfa_pkg::cfg_t       cfg,
  input  qsfa_pkg::frm_state_t cur,
  input  qsfa_pkg::seg_t       seg,
  output qsfa_pkg::frm_state_t nxt,
  output qsfa_pkg::res_t       res
);
  import qsfa_pkg::*;

  function automatic logic [QCNT_W-1:0] mod_q(input logic [QCNT_W-1:0] v,
                                              input logic [QCNT_W-1:0] q);
    logic [QCNT_W-1:0] r;
    case (q)
      3'd1: r = '0;
      3'd2: r = {2'b00, v[0]};
      3'd3: begin
        if (v < 3'd3)      r = v;
        else if (v < 3'd6) r = v - 3'd3;
        else               r = v - 3'd6;
      end
      default: r = {1'b0, v[1:0]};
    endcase
    return r;
  endfunction

  logic [QCNT_W-1:0] q;
  logic [QCNT_W-1:0] segs0, segs1;
  logic [NQUAD-1:0]  mask0, mask1, qbit;
  logic [2:0]        dmg_flags;
  logic [FNUM_W-1:0] new_last, diff;
  logic [QCNT_W-1:0] have, missing;
  logic [DMG_W-1:0]  dmg, applied;
  logic              kept, start, udmg;

  always_comb begin
    if (cfg.quad_count == 3'd0)     q = 3'd1;
    else if (cfg.quad_count > 3'd4) q = 3'd4;
    else                            q = cfg.quad_count;

    qbit      = NQUAD'(1) << seg.quad_id;
    segs0     = mod_q(cur.segs, q);
    start     = (segs0 == '0);
    mask0     = start ? '0 : cur.seen;
    dmg_flags = {seg.len_fault, seg.rx_overflow, seg.end_frame_error};
    kept      = !(seg.short_read || seg.read_fail);
    new_last  = seg.frame_number - 32'd1;
    diff      = new_last - cur.last_frame;
    have      = QCNT_W'(mask0[0]) + QCNT_W'(mask0[1]) + QCNT_W'(mask0[2])
              + QCNT_W'(mask0[3]);
    missing   = '0;
    udmg      = 1'b0;
    applied   = '0;
    dmg       = {5'b00000, dmg_flags};
    segs1     = segs0;
    mask1     = mask0;
    nxt.last_frame = cur.last_frame;

    if (dmg_flags != 3'b000) begin
      if (kept) begin
        dmg     = dmg | LINK_ERR_DMG;
        udmg    = 1'b1;
        applied = dmg;
      end
    end else begin
      nxt.last_frame = new_last;
      if (new_last != cur.last_frame && segs0 != '0 && !cfg.sequence_mode) begin
        if (new_last < cur.last_frame || diff > FRAME_JUMP_MAX) begin
          kept = 1'b0;
        end else begin
          missing = (have < q) ? q - have : '0;
          segs1   = '0;
          mask1   = qbit;
          start   = 1'b1;
          kept    = 1'b1;
        end
      end
    end

    if (kept) begin
      segs1 = segs1 + 3'd1;
      if ((mask1 & qbit) != '0) begin
        dmg     = dmg | DUP_QUAD_DMG | {4'b0000, qbit};
        udmg    = 1'b1;
        applied = dmg;
      end
      mask1 = mask1 | qbit;
    end

    nxt.segs = segs1;
    nxt.seen = mask1;

    res.accepted      = kept;
    res.frame_start   = start;
    res.segment_index = segs1;
    res.damage_bits   = applied;
    res.user_damage   = udmg;
    res.missing_quads = missing;
    res.frame_count   = nxt.last_frame;
  end

endmodule
